@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the escape-time checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define MBET_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Checked on every rising clock edge, reset included.
`define MBET_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

@@ sv/mbet_pkg.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Widths, fixed-point constants and the core status bundle.
// ----------------------------------------------------------------------------
package mbet_pkg;

   // Input point in signed Q4.28, orbit value z in signed Q7.28.
   localparam int FracBits  = 28;
   localparam int PointW    = 32;
   localparam int ZW        = 35;
   // Magnitude of a z component stays below 16, so 32 bits hold it.
   localparam int MagW      = 32;
   localparam int ProdW     = 2 * MagW;
   // A square truncated back to Q.28.
   localparam int SqW       = ProdW - FracBits;
   // Doubled cross product truncated back to Q.28.
   localparam int CrossW    = ProdW + 1 - FracBits;
   // Working width of the update sums.
   localparam int SumW      = CrossW + 1;
   localparam int CountW    = 16;

   localparam logic [CountW-1:0] LimitReset = CountW'(1000);
   // Escape threshold 4.0 in Q.28.
   localparam logic [SqW:0] Threshold = (SqW+1)'(4) << FracBits;
   localparam logic [FracBits-1:0] FracMask = '1;

   // Status from the core to the top level.
   typedef struct packed {
      logic              idle;
      logic              done;
      logic [CountW-1:0] count;
   } mbet_status_type;

endpackage

@@ sv/mbet_mult.sv @@
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 x 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module mbet_mult (
   input  logic                        clock,
   input  logic [mbet_pkg::MagW-1:0]   op_a,
   input  logic [mbet_pkg::MagW-1:0]   op_b,
   output logic [mbet_pkg::ProdW-1:0]  product_ff
);

   // The product of the operands is registered in product_ff.
   always_ff @(posedge clock) begin
      product_ff <= op_a * op_b;
   end

endmodule

@@ sv/mbet_core.sv @@
// ----------------------------------------------------------------------------
// Escape-time iteration core
// Sequencer that runs z = z*z + c through one shared multiplier.
// ----------------------------------------------------------------------------
module mbet_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mbet_pkg::PointW-1:0]     point_real,
   input  logic [mbet_pkg::PointW-1:0]     point_imag,
   input  logic [mbet_pkg::CountW-1:0]     limit,
   input  logic                            out_ready,
   output mbet_pkg::mbet_status_type       status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQ_RE,
      S_SQ_IM,
      S_CROSS,
      S_UPDATE,
      S_EMIT
   } state_type;

   state_type                          state_ff, state_in;
   logic signed [mbet_pkg::ZW-1:0]     zr_ff, zr_in;
   logic signed [mbet_pkg::ZW-1:0]     zi_ff, zi_in;
   logic signed [mbet_pkg::PointW-1:0] cr_ff, cr_in;
   logic signed [mbet_pkg::PointW-1:0] ci_ff, ci_in;
   logic [mbet_pkg::SqW-1:0]           sr_ff, sr_in;
   logic [mbet_pkg::SqW-1:0]           si_ff, si_in;
   logic [mbet_pkg::CountW-1:0]        step_ff, step_in;
   logic [mbet_pkg::CountW-1:0]        result_ff, result_in;

   logic [mbet_pkg::MagW-1:0]          ar, ai, op_a, op_b;
   logic [mbet_pkg::ZW-1:0]            zr_neg, zi_neg;
   logic [mbet_pkg::ProdW-1:0]         product;
   logic [mbet_pkg::SqW-1:0]           prod_sq;
   logic [mbet_pkg::SqW:0]             mag_sum;
   logic [mbet_pkg::ProdW:0]           cross_dbl;
   logic [mbet_pkg::ProdW:0]           cross_rnd;
   logic [mbet_pkg::CrossW-1:0]        cross_q;
   logic                               cross_neg;
   logic signed [mbet_pkg::SumW-1:0]   re_next, im_next;
   logic [mbet_pkg::CountW-1:0]        step_inc;

   // Magnitudes of the current z; both stay below 16 before each test.
   always_comb begin
      zr_neg = -zr_ff;
      zi_neg = -zi_ff;
      ar     = zr_ff[mbet_pkg::ZW-1] ? zr_neg[mbet_pkg::MagW-1:0]
                                     : zr_ff[mbet_pkg::MagW-1:0];
      ai     = zi_ff[mbet_pkg::ZW-1] ? zi_neg[mbet_pkg::MagW-1:0]
                                     : zi_ff[mbet_pkg::MagW-1:0];
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      op_a = ar;
      op_b = ar;
      unique case (state_ff)
         S_SQ_IM: begin
            op_a = ai;
            op_b = ai;
         end
         S_CROSS: begin
            op_a = ar;
            op_b = ai;
         end
         default: begin
            op_a = ar;
            op_b = ar;
         end
      endcase
   end

   mbet_mult u_mult (
      .clock      (clock),
      .op_a       (op_a),
      .op_b       (op_b),
      .product_ff (product)
   );

   // Square truncated to Q.28 and the escape test sum.
   assign prod_sq = product[mbet_pkg::ProdW-1:mbet_pkg::FracBits];
   assign mag_sum = {1'b0, sr_ff} + {1'b0, prod_sq};

   // Doubled cross product, shifted down by flooring toward minus infinity.
   always_comb begin
      cross_dbl = {product, 1'b0};
      cross_neg = zr_ff[mbet_pkg::ZW-1] ^ zi_ff[mbet_pkg::ZW-1];
      cross_rnd = cross_neg ? cross_dbl + (mbet_pkg::ProdW+1)'(mbet_pkg::FracMask)
                            : cross_dbl;
      cross_q   = cross_rnd[mbet_pkg::ProdW:mbet_pkg::FracBits];
   end

   // Next orbit value.
   always_comb begin
      re_next = $signed({2'b00, sr_ff}) - $signed({2'b00, si_ff})
              + mbet_pkg::SumW'(cr_ff);
      im_next = cross_neg ? mbet_pkg::SumW'(ci_ff) - $signed({1'b0, cross_q})
                          : mbet_pkg::SumW'(ci_ff) + $signed({1'b0, cross_q});
      step_inc = step_ff + 1'b1;
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in  = state_ff;
      zr_in     = zr_ff;
      zi_in     = zi_ff;
      cr_in     = cr_ff;
      ci_in     = ci_ff;
      sr_in     = sr_ff;
      si_in     = si_ff;
      step_in   = step_ff;
      result_in = result_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               zr_in     = '0;
               zi_in     = '0;
               cr_in     = point_real;
               ci_in     = point_imag;
               step_in   = '0;
               result_in = '0;
               state_in  = (limit == '0) ? S_EMIT : S_SQ_RE;
            end
         end
         S_SQ_RE: begin
            state_in = S_SQ_IM;
         end
         S_SQ_IM: begin
            sr_in    = prod_sq;
            state_in = S_CROSS;
         end
         S_CROSS: begin
            // Escape when re*re + im*im is strictly above 4.0.
            si_in = prod_sq;
            if (mag_sum > mbet_pkg::Threshold) begin
               result_in = step_ff;
               state_in  = S_EMIT;
            end else begin
               state_in  = S_UPDATE;
            end
         end
         S_UPDATE: begin
            zr_in   = re_next[mbet_pkg::ZW-1:0];
            zi_in   = im_next[mbet_pkg::ZW-1:0];
            step_in = step_inc;
            if (step_inc == limit) begin
               result_in = '0;
               state_in  = S_EMIT;
            end else begin
               state_in  = S_SQ_RE;
            end
         end
         S_EMIT: begin
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      zr_ff     <= zr_in;
      zi_ff     <= zi_in;
      cr_ff     <= cr_in;
      ci_ff     <= ci_in;
      sr_ff     <= sr_in;
      si_ff     <= si_in;
      step_ff   <= step_in;
      result_ff <= result_in;
   end

   assign status.idle  = (state_ff == S_IDLE);
   assign status.done  = (state_ff == S_EMIT);
   assign status.count = result_ff;

endmodule

@@ sv/mandelbrot_escape_time.sv @@
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Takes a point c, iterates z = z*z + c and returns the escape step index.
// ----------------------------------------------------------------------------
// Usage:
// A point arrives as one beat on the req_ channel: req_tdata holds the real
// part in bits 31:0 and the imaginary part in bits 63:32, both signed Q4.28.
// The block returns one beat on the rsp_ channel whose rsp_tdata is the step
// index at which |z|^2 first exceeds 4.0, or 0 when the iteration limit runs
// out. The limit is written through csr_wr_en and csr_wr_data; the user
// must do so only while idle, since the block itself does not enforce it.
// Each iteration runs on the single shared multiplier: the two squares and
// the cross product, then the update. req_tready is high only while no
// point is in work, so one point is processed at a time.
// The result sits in an output register; a new point may be accepted while
// it waits. If the receiver stalls and a second result is ready, the core
// holds it until the output register frees up.
// Reset clears both channels and sets the limit to 1000.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
   input  logic        clock,
   input  logic        reset,
   // Configuration port: iteration limit.
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // Input point: point_real [31:0], point_imag [63:32].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // Result: escape_count [15:0].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata
);

   logic [mbet_pkg::CountW-1:0] limit_ff;
   logic                        rsp_valid_ff;
   logic [mbet_pkg::CountW-1:0] rsp_data_ff;
   logic                        out_free;
   mbet_pkg::mbet_status_type   status;

   // Iteration limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= mbet_pkg::LimitReset;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   mbet_core u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (req_tvalid),
      .point_real (req_tdata[31:0]),
      .point_imag (req_tdata[63:32]),
      .limit      (limit_ff),
      .out_ready  (out_free),
      .status     (status)
   );

   // Output register holds the result beat until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.done && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (status.done && out_free) begin
         rsp_data_ff <= status.count;
      end
   end

   assign req_tready = status.idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ sv/mbet_checker.sv @@
// ----------------------------------------------------------------------------
// Escape-time port checker
// Watches the top-level ports and checks beat ordering and result range.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbet_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // No result beat is offered in the cycle after reset.
   `MBET_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_tvalid)

   // A stalled result beat keeps its value.
   `MBET_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // Once a point is taken the block is busy with it on the next cycle.
   `MBET_ASSERT(a_busy_after_accept, clock, reset,
      req_tvalid && req_tready |=> !req_tready)

   // An escape index is always below the largest limit.
   `MBET_ASSERT(a_count_range, clock, reset, rsp_tvalid |-> rsp_tdata != 16'hFFFF)

endmodule

bind mandelbrot_escape_time mbet_checker u_mbet_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Escape-time unit testbench
// Drives complex points into the escape-time unit over several iteration
// limits, predicts each escape step with its own fixed-point orbit model and
// checks every result beat in order. Both channels idle at random, and one
// long receiver hold-off fills the unit until it stalls its input.
// ----------------------------------------------------------------------------
module testbench;

   // Fixed-point values of interest in Q4.28.
   localparam bit [mbet_pkg::PointW-1:0] QZero    = 32'h0000_0000;
   localparam bit [mbet_pkg::PointW-1:0] QOne     = 32'h1000_0000;
   localparam bit [mbet_pkg::PointW-1:0] QTwo     = 32'h2000_0000;
   localparam bit [mbet_pkg::PointW-1:0] QNegTwo  = 32'hE000_0000;
   localparam bit [mbet_pkg::PointW-1:0] QQuarter = 32'h0400_0000;
   localparam bit [mbet_pkg::PointW-1:0] QNegOne  = 32'hF000_0000;
   localparam bit [mbet_pkg::PointW-1:0] QPosMax  = 32'h7FFF_FFFF;
   localparam bit [mbet_pkg::PointW-1:0] QNegMax  = 32'h8000_0000;
   localparam bit [mbet_pkg::PointW-1:0] QLsb     = 32'h0000_0001;
   localparam bit [mbet_pkg::PointW-1:0] QNegLsb  = 32'hFFFF_FFFF;

   localparam bit [mbet_pkg::CountW-1:0] LimitMax = 16'hFFFF;
   localparam int StallLimit   = 1_000_000;
   localparam int HoldCycles   = 600;
   localparam int TailCycles   = 64;
   localparam int PrintLimit   = 200;
   localparam int RandomPhases = 10;
   localparam int PhaseItems   = 60;

   typedef enum {CountMatch, CountUnexpected, CountWrong} check_status_type;

   // Expected escape counts, one per accepted point, oldest first.
   class escape_scoreboard;
      bit [mbet_pkg::CountW-1:0] iter_limit;
      bit [mbet_pkg::CountW-1:0] pending_counts[$];

      function new();
         iter_limit = mbet_pkg::LimitReset;
      endfunction

      // Orbit z = z*z + c from z = 0 in Q7.28, squares truncated and the
      // doubled cross product floored back to Q.28.
      static function bit [mbet_pkg::CountW-1:0] escape_step(
            bit [mbet_pkg::PointW-1:0] re_bits,
            bit [mbet_pkg::PointW-1:0] im_bits,
            bit [mbet_pkg::CountW-1:0] limit);
         longint c_re, c_im, z_re, z_im, sq_re, sq_im, next_re;
         bit [63:0] mag_re, mag_im, cross_dbl;
         bit neg, escaped;
         int unsigned step;
         bit [mbet_pkg::CountW-1:0] found;
         c_re = longint'(signed'(re_bits));
         c_im = longint'(signed'(im_bits));
         z_re = 0;
         z_im = 0;
         found = '0;
         escaped = 1'b0;
         step = 0;
         while (!escaped && step < limit) begin
            mag_re = (z_re < 0) ? -z_re : z_re;
            mag_im = (z_im < 0) ? -z_im : z_im;
            sq_re = longint'((mag_re * mag_re) >> mbet_pkg::FracBits);
            sq_im = longint'((mag_im * mag_im) >> mbet_pkg::FracBits);
            if (sq_re + sq_im > (longint'(4) <<< mbet_pkg::FracBits)) begin
               escaped = 1'b1;
               found = mbet_pkg::CountW'(step);
            end else begin
               cross_dbl = (mag_re * mag_im) << 1;
               neg = ((z_re < 0) != (z_im < 0)) && (cross_dbl != 0);
               next_re = sq_re - sq_im + c_re;
               if (neg) begin
                  z_im = c_im - longint'((cross_dbl + 64'(mbet_pkg::FracMask))
                                         >> mbet_pkg::FracBits);
               end else begin
                  z_im = c_im + longint'(cross_dbl >> mbet_pkg::FracBits);
               end
               z_re = next_re;
               step++;
            end
         end
         return found;
      endfunction

      function void note_point(bit [mbet_pkg::PointW-1:0] re_bits,
                               bit [mbet_pkg::PointW-1:0] im_bits);
         pending_counts.push_back(escape_step(re_bits, im_bits, iter_limit));
      endfunction

      function check_status_type check_count(logic [mbet_pkg::CountW-1:0] got,
                                             output bit [mbet_pkg::CountW-1:0] want);
         want = '0;
         if (pending_counts.size() == 0) return CountUnexpected;
         want = pending_counts.pop_front();
         return (got === want) ? CountMatch : CountWrong;
      endfunction

      function int pending_count();
         return pending_counts.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;

   escape_scoreboard sb;
   int error_count    = 0;
   int points_sent    = 0;
   int limits_written = 0;
   int escaped_seen   = 0;
   int inside_seen    = 0;
   int deepest_step   = 0;
   int hold_requests  = 0;
   int idle_cycles    = 0;

   mandelbrot_escape_time dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PrintLimit) $display("mismatch: %s", what);
   endtask

   // Random idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(40, 120);
   endfunction

   // Mostly points around the set, where orbits run long; the rest is
   // full-range noise and a few exact boundary values.
   task automatic pick_point(output bit [mbet_pkg::PointW-1:0] re,
                             output bit [mbet_pkg::PointW-1:0] im);
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         re = $urandom_range(0, 32'h3000_0000) - 32'h2400_0000;
         im = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
      end else if (r < 92) begin
         re = $urandom;
         im = $urandom;
      end else begin
         case ($urandom_range(0, 4))
            0: begin re = QNegTwo;  im = QZero;   end
            1: begin re = QQuarter; im = QZero;   end
            2: begin re = QZero;    im = QOne;    end
            3: begin re = QTwo;     im = $urandom_range(0, 3); end
            default: begin re = QPosMax; im = QNegMax; end
         endcase
      end
   endtask

   // Offer one point and hold it until the unit takes the beat.
   task automatic send_point(input bit [mbet_pkg::PointW-1:0] re,
                             input bit [mbet_pkg::PointW-1:0] im,
                             input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {im, re};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      points_sent++;
   endtask

   // Stop offering and wait for every pending result beat.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending_count() != 0) @(negedge clock);
   endtask

   task automatic set_limit(input bit [mbet_pkg::CountW-1:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.iter_limit = value;
      limits_written++;
   endtask

   // Receiver: random stalls, clean stretches and a requested long hold-off.
   initial begin : receiver
      int stall_left;
      int clear_left;
      int hold_seen;
      int r;
      stall_left = 0;
      clear_left = 0;
      hold_seen = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            stall_left = HoldCycles;
            clear_left = 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (clear_left > 0) begin
            rsp_tready <= 1'b1;
            clear_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 5) clear_left = $urandom_range(20, 80);
            stall_left = (r < 5) ? 0 : pick_gap();
            rsp_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // Beat monitor: note accepted points, check accepted results.
   always @(posedge clock) begin : monitor
      bit [mbet_pkg::CountW-1:0] want;
      check_status_type status;
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_point(req_tdata[31:0], req_tdata[63:32]);
         if (rsp_tvalid && rsp_tready) begin
            status = sb.check_count(rsp_tdata, want);
            if (status == CountUnexpected) begin
               report_mismatch($sformatf("result %0d with no point pending", rsp_tdata));
            end else if (status == CountWrong) begin
               report_mismatch($sformatf("escape_count %0d, expected %0d",
                                         rsp_tdata, want));
            end
            if (want != 0) begin
               escaped_seen++;
               if (want > deepest_step) deepest_step = want;
            end else begin
               inside_seen++;
            end
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("watchdog: no beat for %0d cycles", idle_cycles);
         $display("testbench: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main sequence: directed points, random phases, drain and verdict.
   initial begin : stimulus
      bit [mbet_pkg::PointW-1:0] re, im;
      bit no_gaps;
      sb = new();
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed points under the reset limit.
      send_point(QZero, QZero, 0);
      send_point(QNegTwo, QZero, 0);
      send_point(QTwo, QZero, 1);
      send_point(QPosMax, QPosMax, 0);
      send_point(QNegMax, QNegMax, 0);
      send_point(QNegMax, QPosMax, 2);
      send_point(QPosMax, QNegMax, 0);
      send_point(QQuarter, QZero, 0);
      send_point(32'hF400_0000, 32'h0199_999A, 0);
      send_point(QZero, QOne, 3);
      send_point(QNegOne, QZero, 0);
      send_point(32'h0428_F5C3, QZero, 0);
      send_point(QLsb, QNegLsb, 0);
      send_point(QNegLsb, QNegLsb, 0);

      // Limit of one: only step zero is tested, and it never escapes.
      set_limit(16'd1);
      send_point(QPosMax, QPosMax, 0);
      send_point(QZero, QZero, 0);
      // Zero limit: no step runs at all.
      set_limit(16'd0);
      send_point(QNegMax, QNegMax, 0);
      send_point(QTwo, QTwo, 0);
      set_limit(16'd2);
      send_point(QNegMax, QZero, 0);
      send_point(QNegOne, QOne, 0);
      // Largest limit: one point that escapes at step one and one that stays inside the whole way.
      set_limit(LimitMax);
      send_point(QNegMax, QPosMax, 0);
      send_point(QZero, QZero, 0);

      // Random phases, each under its own limit.
      for (int phase = 0; phase < RandomPhases; phase++) begin
         case (phase % 5)
            0: set_limit(mbet_pkg::CountW'($urandom_range(1, 3)));
            1: set_limit(mbet_pkg::CountW'($urandom_range(4, 16)));
            2: set_limit(mbet_pkg::CountW'($urandom_range(17, 48)));
            3: set_limit(mbet_pkg::CountW'($urandom_range(49, 128)));
            default: set_limit(mbet_pkg::CountW'($urandom_range(1, 24)));
         endcase
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < PhaseItems; i++) begin
            pick_point(re, im);
            send_point(re, im, no_gaps ? 0 : pick_gap());
         end

         // Once: hold the receiver off while points keep coming back to back.
         if (phase == 2) begin
            set_limit(16'd6);
            hold_requests++;
            for (int i = 0; i < 8; i++) begin
               pick_point(re, im);
               send_point(re, im, 0);
            end
         end
      end

      wait_drained();
      repeat (TailCycles) @(negedge clock);
      if (sb.pending_count() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", sb.pending_count()));
      end

      $display("run covered %0d points under %0d limit writes, limits 0 through %0d",
               points_sent, limits_written, LimitMax);
      $display("%0d points escaped (deepest at step %0d), %0d stayed inside",
               escaped_seen, deepest_step, inside_seen);
      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/mbet_pkg.sv
sv/mbet_mult.sv
sv/mbet_core.sv
sv/mandelbrot_escape_time.sv
sv/mbet_checker.sv
test/testbench.sv
